FILE: hw/rtl/pfd_pkg.sv
`timescale 1ns / 1ps

package pfd_pkg;

  // pixel format codes
  typedef enum logic [2:0] {
    FMT_RGBA8   = 3'd0,
    FMT_BGRA8   = 3'd1,
    FMT_RGB10A2 = 3'd2,
    FMT_HALF    = 3'd3,
    FMT_NONE    = 3'd4
  } pix_fmt_t;

  localparam logic [31:0] F32_ONE    = 32'h3F80_0000;
  localparam logic [31:0] F32_INF    = 32'h7F80_0000;
  localparam logic [7:0]  EXP_BIAS_H = 8'd112;
  localparam logic [7:0]  EXP_UNORM  = 8'd126;

  // leading zeros of a 10-bit code, code known nonzero
  function automatic logic [3:0] lz10(input logic [9:0] v);
    logic [3:0] n;
    logic       hit;
    n   = 4'd0;
    hit = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!hit && v[i]) begin
        hit = 1'b1;
        n   = 4'(9 - i);
      end
    end
    return n;
  endfunction

  // n / (2^w - 1) is the binary fraction 0.nnnn... with n repeating;
  // normalize, take 24 bits, round on the next bit (never a tie)
  function automatic logic [31:0] unorm_from_stream(input logic [39:0] s,
                                                    input logic [3:0] lz);
    logic [39:0] sh;
    logic [7:0]  ex;
    sh = s << lz;
    ex = EXP_UNORM - {4'd0, lz};
    return {1'b0, ex, sh[38:16]} + {31'd0, sh[15]};
  endfunction

  function automatic logic [31:0] unorm8_bits(input logic [7:0] c);
    logic [31:0] res;
    if (c == 8'd0)
      res = 32'd0;
    else if (c == 8'hFF)
      res = F32_ONE;
    else
      res = unorm_from_stream({c, c, c, c, c}, lz10({2'b00, c}) - 4'd2);
    return res;
  endfunction

  function automatic logic [31:0] unorm10_bits(input logic [9:0] c);
    logic [31:0] res;
    if (c == 10'd0)
      res = 32'd0;
    else if (c == 10'h3FF)
      res = F32_ONE;
    else
      res = unorm_from_stream({c, c, c, c}, lz10(c));
    return res;
  endfunction

  // exact half to single widening
  function automatic logic [31:0] half_bits(input logic [15:0] h);
    logic [31:0] res;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  k;
    logic [10:0] mn;
    ex  = h[14:10];
    man = h[9:0];
    k   = lz10(man);
    mn  = {1'b0, man} << (k + 4'd1);
    if (ex == 5'd0) begin
      if (man == 10'd0)
        res = {h[15], 31'd0};
      else
        res = {h[15], EXP_BIAS_H - {4'd0, k}, mn[9:0], 13'd0};
    end else if (ex == 5'h1F) begin
      res = {h[15], 31'd0} | F32_INF | {9'd0, man, 13'd0};
    end else begin
      res = {h[15], {3'd0, ex} + EXP_BIAS_H, man, 13'd0};
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/pfd_if.sv
`timescale 1ns / 1ps

// input word channel
interface pfd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_pixel;
  modport source (output valid, output raw_pixel, input ready);
  modport sink (input valid, input raw_pixel, output ready);
endinterface

// result word channel
interface pfd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] red_bits;
  logic [31:0] green_bits;
  logic [31:0] blue_bits;
  modport source (output valid, output red_bits, output green_bits, output blue_bits,
                  input ready);
  modport sink (input valid, input red_bits, input green_bits, input blue_bits,
                output ready);
endinterface

// format register write channel
interface pfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] pixel_format;
  modport source (output valid, output pixel_format, input ready);
  modport sink (input valid, input pixel_format, output ready);
endinterface

FILE: hw/rtl/pfd_conv.sv
`timescale 1ns / 1ps

module pfd_conv (
  input  pfd_pkg::pix_fmt_t fmt,
  input  logic [63:0]       px,
  output logic [31:0]       red,
  output logic [31:0]       green,
  output logic [31:0]       blue
);
  import pfd_pkg::*;

  // per-format channel decode
  always_comb begin
    red   = 32'd0;
    green = 32'd0;
    blue  = 32'd0;
    unique case (fmt)
      FMT_RGBA8: begin
        red   = unorm8_bits(px[7:0]);
        green = unorm8_bits(px[15:8]);
        blue  = unorm8_bits(px[23:16]);
      end
      FMT_BGRA8: begin
        blue  = unorm8_bits(px[7:0]);
        green = unorm8_bits(px[15:8]);
        red   = unorm8_bits(px[23:16]);
      end
      FMT_RGB10A2: begin
        red   = unorm10_bits(px[9:0]);
        green = unorm10_bits(px[19:10]);
        blue  = unorm10_bits(px[29:20]);
      end
      FMT_HALF: begin
        red   = half_bits(px[15:0]);
        green = half_bits(px[31:16]);
        blue  = half_bits(px[47:32]);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/pixel_format_to_float_decode.sv
`timescale 1ns / 1ps
// an accepted input word goes through the input register, then the result register
// throughput: one word per cycle while out_ch.ready is high, set by the
// two-register pipeline (input register, conversion logic, result register)
// reset: synchronous active-low rst_n clears both stage valids and sets
// the format to rgba8
module pixel_format_to_float_decode (
  input logic       clk,
  input logic       rst_n,
  pfd_in_if.sink    in_ch,
  pfd_out_if.source out_ch,
  pfd_cfg_if.sink   cfg_ch
);
  import pfd_pkg::*;

  logic [2:0]  fmt_cfg_r;
  logic        v1_r, v2_r;
  logic [63:0] px_r;
  logic [2:0]  fmt_r;
  logic [31:0] red_r, green_r, blue_r;
  logic [31:0] red_nxt, green_nxt, blue_nxt;
  logic        adv1, adv2;

  assign cfg_ch.ready = 1'b1;
  assign adv2         = !v2_r || out_ch.ready;
  assign adv1         = !v1_r || adv2;
  assign in_ch.ready  = adv1;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n)
      fmt_cfg_r <= FMT_RGBA8;
    else if (cfg_ch.valid)
      fmt_cfg_r <= cfg_ch.pixel_format;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1)
        v1_r <= in_ch.valid;
      if (adv2)
        v2_r <= v1_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      px_r  <= in_ch.raw_pixel;
      fmt_r <= fmt_cfg_r;
    end
  end

  pfd_conv u_conv (
    .fmt   (pix_fmt_t'(fmt_r)),
    .px    (px_r),
    .red   (red_nxt),
    .green (green_nxt),
    .blue  (blue_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid      = v2_r;
  assign out_ch.red_bits   = red_r;
  assign out_ch.green_bits = green_r;
  assign out_ch.blue_bits  = blue_r;

  // pipeline checks
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r))
    else $error("input blocked with a free stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv2) |=> v2_r)
    else $error("word lost between stages");

  a_unsupported_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv2 && fmt_r[2]) |=>
      (red_r == 32'd0 && green_r == 32'd0 && blue_r == 32'd0))
    else $error("unsupported format gave nonzero result");

endmodule
